/* rtl/core/rfla_pkg.sv */
// Shared types, codes and constants of the receive FIFO line assembler.
package rfla_pkg;

   localparam int BYTE_W         = 8;
   localparam int LINE_W         = 12;
   localparam int OP_W           = 2;
   localparam int FIFO_DEPTH_DEF = 64;
   localparam int MAX_LINE_DEF   = 4095;
   localparam int CMDQ_DEPTH     = 2;
   localparam int RSPQ_DEPTH     = 4;
   localparam int RSPQ_CNT_W     = $clog2(RSPQ_DEPTH + 1);

   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

   localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd0;
   localparam logic [OP_W-1:0] OP_LINE    = 2'd1;
   localparam logic [OP_W-1:0] OP_POLL    = 2'd2;

   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_LINE,
      CMD_POLL
   } rfla_cmd_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } rfla_state_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] rx_byte;
      logic [LINE_W-1:0] line_cap;
   } rfla_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      logic              byte_valid;
      logic [LINE_W-1:0] byte_index;
      logic              line_done;
      logic              end_cause;
   } rfla_rsp_type;

   typedef struct packed {
      rfla_cmd_kind_type kind;
      logic [BYTE_W-1:0] rx_byte;
      logic [LINE_W-1:0] cap;
   } rfla_cmd_type;

endpackage

/* rtl/core/rfla_queue.sv */
// Small register queue used between the front, the back and the result port.
module rfla_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  item_type                     wr_item,
   output logic                         full,
   input  logic                         rd_en,
   output item_type                     rd_item,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_ok, pop_ok;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_item = slots_ff[rd_ptr_ff];
   assign push_ok = wr_en && !full;
   assign pop_ok  = rd_en && !empty;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slots_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

/* rtl/core/rfla_front.sv */
// Front end: takes requests, sorts them by operation and clamps the line capacity.
module rfla_front #(
   parameter int MAX_LINE = rfla_pkg::MAX_LINE_DEF
) (
   input  logic                  push,
   input  rfla_pkg::rfla_req_type req_data,
   output logic                  full,
   input  logic                  cmd_full,
   output logic                  cmd_wr,
   output rfla_pkg::rfla_cmd_type cmd_item
);
   import rfla_pkg::*;

   logic [LINE_W-1:0] cap_clamped;
   logic              op_known;

   always_comb begin
      cap_clamped = req_data.line_cap;
      if (req_data.line_cap == '0) begin
         cap_clamped = LINE_W'(1);
      end else if (int'(req_data.line_cap) > MAX_LINE) begin
         cap_clamped = LINE_W'(MAX_LINE);
      end
   end

   always_comb begin
      op_known         = 1'b1;
      cmd_item.kind    = CMD_PUSH;
      cmd_item.rx_byte = req_data.rx_byte;
      cmd_item.cap     = cap_clamped;
      case (req_data.op)
         OP_RX_BYTE: begin
            cmd_item.kind = CMD_PUSH;
         end
         OP_LINE: begin
            cmd_item.kind = CMD_LINE;
         end
         OP_POLL: begin
            cmd_item.kind = CMD_POLL;
         end
         default: begin
            op_known = 1'b0;
         end
      endcase
   end

   assign full   = cmd_full;
   assign cmd_wr = push && !cmd_full && op_known;

endmodule

/* rtl/core/rfla_back.sv */
// Back end: byte FIFO memory, line request state and the drain pipeline.
module rfla_back #(
   parameter int FIFO_DEPTH = rfla_pkg::FIFO_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_empty,
   input  rfla_pkg::rfla_cmd_type              cmd_item,
   output logic                                cmd_pop,
   input  logic [rfla_pkg::RSPQ_CNT_W-1:0]     rsp_count,
   output logic                                rsp_wr,
   output rfla_pkg::rfla_rsp_type              rsp_item
);
   import rfla_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int ROOM_W = RSPQ_CNT_W + 1;

   logic [BYTE_W-1:0] mem [FIFO_DEPTH];

   rfla_state_type    state_ff, state_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pending_ff, pending_in;
   logic [LINE_W-1:0] length_ff, length_in;
   logic [LINE_W-1:0] limit_ff, limit_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  rd_left_ff, rd_left_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [BYTE_W-1:0] rd_data_ff;

   logic              mem_wr;
   logic              issue;
   logic              finish;
   logic [SUM_W-1:0]  wr_sum;
   logic [SUM_W-1:0]  wr_slot;
   logic [PTR_W-1:0]  wr_addr;
   logic [LINE_W-1:0] length_next;
   logic [ROOM_W-1:0] rsp_used;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] result;
      if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

   assign wr_sum      = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign wr_slot     = (wr_sum >= SUM_W'(FIFO_DEPTH)) ? wr_sum - SUM_W'(FIFO_DEPTH) : wr_sum;
   assign wr_addr     = wr_slot[PTR_W-1:0];
   assign length_next = length_ff + 1'b1;
   assign rsp_used    = ROOM_W'(rsp_count) + ROOM_W'(rd_vld_ff);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      length_in  = length_ff;
      limit_in   = limit_ff;
      rd_ptr_in  = rd_ptr_ff;
      rd_left_in = rd_left_ff;
      cmd_pop    = 1'b0;
      mem_wr     = 1'b0;
      issue      = 1'b0;
      finish     = 1'b0;
      rsp_wr     = 1'b0;
      rsp_item   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_item.kind)
                  CMD_PUSH: begin
                     if (count_ff < CNT_W'(FIFO_DEPTH)) begin
                        mem_wr   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_LINE: begin
                     if (!pending_ff) begin
                        pending_in = 1'b1;
                        length_in  = '0;
                        limit_in   = cmd_item.cap;
                     end
                  end
                  CMD_POLL: begin
                     if (pending_ff && count_ff != '0) begin
                        state_in   = ST_DRAIN;
                        rd_ptr_in  = head_ff;
                        rd_left_in = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (rd_vld_ff) begin
               rsp_wr   = 1'b1;
               head_in  = ptr_next(head_ff);
               count_in = count_ff - 1'b1;
               if (rd_data_ff == NEWLINE_CODE) begin
                  finish              = 1'b1;
                  pending_in          = 1'b0;
                  rsp_item.byte_index = length_ff;
                  rsp_item.line_done  = 1'b1;
               end else begin
                  length_in           = length_next;
                  rsp_item.line_byte  = rd_data_ff;
                  rsp_item.byte_valid = 1'b1;
                  rsp_item.byte_index = length_ff;
                  if (length_next == limit_ff) begin
                     finish             = 1'b1;
                     pending_in         = 1'b0;
                     rsp_item.line_done = 1'b1;
                     rsp_item.end_cause = 1'b1;
                  end
               end
            end
            issue = !finish && (rd_left_ff != '0) && (rsp_used < ROOM_W'(RSPQ_DEPTH));
            if (issue) begin
               rd_ptr_in  = ptr_next(rd_ptr_ff);
               rd_left_in = rd_left_ff - 1'b1;
            end
            if (finish || (rd_left_ff == '0 && !rd_vld_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rd_vld_in = issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         pending_ff <= 1'b0;
         length_ff  <= '0;
         limit_ff   <= '0;
         rd_ptr_ff  <= '0;
         rd_left_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         length_ff  <= length_in;
         limit_ff   <= limit_in;
         rd_ptr_ff  <= rd_ptr_in;
         rd_left_ff <= rd_left_in;
         rd_vld_ff  <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_addr] <= cmd_item.rx_byte;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

endmodule

/* rtl/core/rx_fifo_line_assembler.sv */
// Top level of the receive FIFO line assembler.
// Requests carry a received byte, a line request with a capacity, or a poll. The front
// accepts one request per cycle into a two-entry command queue while it has room; the back
// executes a byte push or a line request as it takes it. A poll with a line pending drains
// the FIFO held at that moment: the poll moves the back to its drain state, then one byte
// per cycle goes through the registered read of the byte memory, as long as the four-entry
// result queue has room. While a drain runs the command queue fills and full rises. Pushes
// to a full FIFO are dropped, a line request while one is pending is ignored, and a drain
// stops at a newline (a terminator-only result) or at the byte reaching the line capacity.
module rx_fifo_line_assembler #(
   parameter int FIFO_DEPTH = rfla_pkg::FIFO_DEPTH_DEF,
   parameter int MAX_LINE   = rfla_pkg::MAX_LINE_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  rfla_pkg::rfla_req_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output rfla_pkg::rfla_rsp_type rsp_data
);
   import rfla_pkg::*;

   logic                  cmd_full, cmd_empty, cmd_wr, cmd_pop;
   rfla_cmd_type          cmd_wr_item, cmd_rd_item;
   logic [$clog2(CMDQ_DEPTH+1)-1:0] cmd_count;
   logic                  rsp_wr;
   rfla_rsp_type          rsp_wr_item;
   logic                  rsp_full;
   logic [RSPQ_CNT_W-1:0] rsp_count;

   rfla_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .cmd_full (cmd_full),
      .cmd_wr   (cmd_wr),
      .cmd_item (cmd_wr_item)
   );

   rfla_queue #(
      .item_type (rfla_cmd_type),
      .DEPTH     (CMDQ_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_wr),
      .wr_item (cmd_wr_item),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_item (cmd_rd_item),
      .empty   (cmd_empty),
      .count   (cmd_count)
   );

   rfla_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty || (cmd_count == '0)),
      .cmd_item  (cmd_rd_item),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_wr    (rsp_wr),
      .rsp_item  (rsp_wr_item)
   );

   rfla_queue #(
      .item_type (rfla_rsp_type),
      .DEPTH     (RSPQ_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_wr && !rsp_full),
      .wr_item (rsp_wr_item),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_item (rsp_data),
      .empty   (empty),
      .count   (rsp_count)
   );

endmodule

/* rtl/core/rfla_checker.sv */
// Port-level checks of the line assembler results, bound to the top level.
module rfla_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   empty,
   input logic                   pop,
   input rfla_pkg::rfla_rsp_type rsp_data
);
   import rfla_pkg::*;

   a_cause_needs_done : assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_data.line_done |-> !rsp_data.end_cause)
      else $error("End cause is set on a result that does not end a line.");

   a_term_ends_line : assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_data.byte_valid |-> rsp_data.line_done && !rsp_data.end_cause)
      else $error("Terminator result does not end its line by newline.");

   a_term_zero_byte : assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_data.byte_valid |-> rsp_data.line_byte == '0)
      else $error("Terminator result carries a nonzero byte.");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("Waiting result changed or vanished before it was taken.");

endmodule

bind rx_fifo_line_assembler rfla_checker u_checker (.*);

/* tb/sv/rfla_line_checker.sv */
// Checker for the receive FIFO line assembler: predicts line results and compares them.
module rfla_line_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  rfla_pkg::rfla_req_type req_data,
   input  logic                   empty,
   input  logic                   pop,
   input  rfla_pkg::rfla_rsp_type rsp_data,
   output int                     fail_count,
   output int                     waiting_count
);
   import rfla_pkg::*;

   localparam int MAX_BURST   = 64;
   localparam int REPORT_MAX  = 10;

   logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH_DEF];
   logic [5:0]        fifo_head;
   logic [6:0]        fifo_count;
   logic              line_open;
   logic [LINE_W-1:0] line_len;
   logic [LINE_W-1:0] line_limit;
   rfla_rsp_type      line_results_q [$];
   rfla_rsp_type      want;
   int                errors = 0;

   task automatic report(input string what, input rfla_rsp_type exp_rsp,
                         input rfla_rsp_type act_rsp);
      errors++;
      if (errors <= REPORT_MAX) begin
         $display("%s: expected byte %h valid %b index %0d done %b cause %b",
                  what, exp_rsp.line_byte, exp_rsp.byte_valid, exp_rsp.byte_index,
                  exp_rsp.line_done, exp_rsp.end_cause);
         $display("   actual byte %h valid %b index %0d done %b cause %b",
                  act_rsp.line_byte, act_rsp.byte_valid, act_rsp.byte_index,
                  act_rsp.line_done, act_rsp.end_cause);
      end
   endtask

   task automatic assemble_request(input rfla_req_type r);
      rfla_rsp_type      res;
      logic [BYTE_W-1:0] ch;
      logic [5:0]        slot;
      int                n;
      bit                stop;
      n = 0;
      case (r.op)
         OP_RX_BYTE: begin
            if (fifo_count < FIFO_DEPTH_DEF) begin
               slot = fifo_head + fifo_count[5:0];
               fifo_mem[slot] = r.rx_byte;
               fifo_count = fifo_count + 1'b1;
            end
         end
         OP_LINE: begin
            if (!line_open) begin
               line_open = 1'b1;
               line_len = '0;
               line_limit = (r.line_cap == '0) ? LINE_W'(1) : r.line_cap;
               if (line_limit > MAX_LINE_DEF) begin
                  line_limit = LINE_W'(MAX_LINE_DEF);
               end
            end
         end
         OP_POLL: begin
            stop = !line_open;
            while (!stop && fifo_count > 0 && n < MAX_BURST) begin
               ch = fifo_mem[fifo_head];
               fifo_head = fifo_head + 1'b1;
               fifo_count = fifo_count - 1'b1;
               res = '0;
               if (ch == NEWLINE_CODE) begin
                  res.byte_index = line_len;
                  res.line_done = 1'b1;
                  line_open = 1'b0;
                  stop = 1'b1;
               end else begin
                  line_len = line_len + 1'b1;
                  res.line_byte = ch;
                  res.byte_valid = 1'b1;
                  res.byte_index = line_len - 1'b1;
                  if (line_len == line_limit) begin
                     res.line_done = 1'b1;
                     res.end_cause = 1'b1;
                     line_open = 1'b0;
                     stop = 1'b1;
                  end
               end
               line_results_q.push_back(res);
               n++;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fifo_head = '0;
         fifo_count = '0;
         line_open = 1'b0;
         line_len = '0;
         line_limit = '0;
         line_results_q.delete();
      end else begin
         if (pop && !empty) begin
            if (line_results_q.size() == 0) begin
               report("Unexpected result", '0, rsp_data);
            end else begin
               want = line_results_q.pop_front();
               if (rsp_data !== want) begin
                  report("Result mismatch", want, rsp_data);
               end
            end
         end
         if (push && !full) begin
            assemble_request(req_data);
         end
      end
      fail_count <= errors;
      waiting_count <= line_results_q.size();
   end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the receive FIFO line assembler: stimulus, pressure, watchdog and verdict.
module tb;
   import rfla_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TOTAL_ITEMS  = 280;
   localparam int TAIL_CYCLES  = 20;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         pop = 1'b0;
   logic         full;
   logic         empty;
   rfla_req_type req_data = '0;
   rfla_rsp_type rsp_data;
   bit           quiet = 1'b0;
   bit           hold_go = 1'b0;
   int           fail_count;
   int           waiting_count;
   int           stall_cycles = 0;
   int           sent = 0;

   rx_fifo_line_assembler DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   rfla_line_checker line_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .waiting_count (waiting_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                       input logic [LINE_W-1:0] cap);
      rfla_req_type item;
      item.op = op;
      item.rx_byte = data;
      item.line_cap = cap;
      req_data <= item;
      push <= 1'b1;
      do @(posedge clock); while (full);
      sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] data);
      send(OP_RX_BYTE, data, LINE_W'($urandom));
   endtask

   task automatic request_line(input logic [LINE_W-1:0] cap);
      send(OP_LINE, BYTE_W'($urandom), cap);
   endtask

   task automatic poll();
      send(OP_POLL, BYTE_W'($urandom), LINE_W'($urandom));
   endtask

   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom);
      return (b == NEWLINE_CODE) ? BYTE_W'(8'h0B) : b;
   endfunction

   initial begin
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_go && !held) begin
            held = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      int                total;
      int                n;
      int                r;
      logic [LINE_W-1:0] cap;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      poll();
      send(OP_UNUSED, BYTE_W'($urandom), LINE_W'($urandom));
      request_line('0);
      poll();
      push_byte(8'h00);
      poll();
      request_line(12'hFFF);
      request_line(12'd5);
      push_byte(8'hFF);
      push_byte(8'h41);
      push_byte(NEWLINE_CODE);
      poll();
      request_line(12'd3);
      push_byte(NEWLINE_CODE);
      poll();
      request_line(12'd2);
      push_byte(8'h01);
      push_byte(8'h02);
      push_byte(8'h03);
      poll();
      request_line(12'hFFF);
      poll();
      push_byte(NEWLINE_CODE);
      poll();

      // Overfill the FIFO and drain it while the receiver is held off.
      hold_go = 1'b1;
      repeat (FIFO_DEPTH_DEF + 6) push_byte(plain_byte());
      request_line(12'hFFF);
      poll();
      repeat (8) push_byte(BYTE_W'($urandom));
      push_byte(NEWLINE_CODE);
      poll();

      total = TOTAL_ITEMS;
      while (sent < total) begin
         if (sent > total - 40) begin
            quiet = 1'b1;
         end
         if ($urandom_range(0, 4) != 0) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
               cap = LINE_W'($urandom);
            end else if (r == 1) begin
               cap = 12'hFFF;
            end else if (r == 2) begin
               cap = '0;
            end else begin
               cap = LINE_W'($urandom_range(1, 12));
            end
            request_line(cap);
            n = $urandom_range(0, 14);
            repeat (n) begin
               push_byte(($urandom_range(0, 7) == 0) ? NEWLINE_CODE : BYTE_W'($urandom));
            end
            poll();
            if ($urandom_range(0, 3) == 0) begin
               poll();
            end
         end else begin
            send(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom), LINE_W'($urandom));
         end
      end

      push <= 1'b0;
      quiet = 1'b1;
      @(posedge clock);
      while (waiting_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
